@@ rtl/grr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, codes and the divider step for the gamma ramp resampler.
// No dependencies; every rtl module imports this package.
package grr_pkg;

    // Field widths fixed by the interface
    localparam int unsigned LVL_W   = 16;   // one channel level
    localparam int unsigned NODE_W  = 10;   // node address field of a load
    localparam int unsigned IDX_W   = 12;   // output_index field
    localparam int unsigned SCNT_W  = 11;   // source_node_count register
    localparam int unsigned TCNT_W  = 13;   // target_node_count register
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LANES   = 3;    // red, green, blue
    localparam int unsigned DATA_W  = 32;   // APB data
    localparam int unsigned ADDR_W  = 3;    // two registers at 0 and 4

    // Parameter defaults and the width used to compare against them
    localparam int unsigned DEF_RAMP_NODES   = 1024;
    localparam int unsigned DEF_TARGET_NODES = 4096;
    localparam int unsigned PAR_W            = 17;

    // Divider widths: the divisor is T-1, below 2**TCNT_W
    localparam int unsigned DEN_W      = TCNT_W;
    localparam int unsigned NUM_W      = 2 * IDX_W;         // i*(S-1), quotient fits IDX_W
    localparam int unsigned PROD_W     = DEN_W + LVL_W;     // weighted node sum
    localparam int unsigned IDX_ITER   = IDX_W / 2;         // two quotient bits a cycle
    localparam int unsigned LVL_ITER   = LVL_W / 2;
    localparam int unsigned IDX_CNT_W  = $clog2(IDX_ITER);
    localparam int unsigned LVL_CNT_W  = $clog2(LVL_ITER);

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FEW   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Register select (paddr bit 2)
    localparam logic REG_SRC = 1'b0;
    localparam logic REG_TGT = 1'b1;

    typedef logic [LANES-1:0][LVL_W-1:0] t_levels;   // [0] red, [1] green, [2] blue

    // Blend weights handed to every lane
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] near;   // T-1-r
        logic [DEN_W-1:0] far;    // r
    } t_weight;

    typedef struct packed {
        logic [LVL_W-1:0]  red;
        logic [LVL_W-1:0]  green;
        logic [LVL_W-1:0]  blue;
        logic [STAT_W-1:0] status;
    } t_result;

    // One restoring division step: returns {quotient bit, new remainder}.
    // The incoming remainder is below den, so the new one is too.
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [DEN_W-1:0] den);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[DEN_W-1:0]};
        end
        return {1'b0, trial[DEN_W-1:0]};
    endfunction

endpackage

@@ rtl/grr_idx_div.sv @@
`timescale 1ns / 1ps
// Index divider: forms i*(S-1) and divides it by T-1, two quotient bits a cycle.
// Depends on grr_pkg.
module grr_idx_div
    import grr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IDX_W-1:0]  i_index,
    input  logic [SCNT_W-1:0] i_span,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_quot,
    output logic [DEN_W-1:0]  o_rem
);

    typedef enum logic [1:0] {D_IDLE, D_INIT, D_ITER} t_dstate;

    t_dstate              r_state;
    logic [IDX_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [IDX_W-1:0]     r_low;   // dividend bits in, quotient bits out
    logic [DEN_W:0]       n_step1;
    logic [DEN_W:0]       n_step2;

    // Two chained restoring steps
    always_comb begin
        n_step1 = div_step(r_rem, r_low[IDX_W-1], r_den);
        n_step2 = div_step(n_step1[DEN_W-1:0], r_low[IDX_W-2], r_den);
    end

    // Multiply, load the partial remainder, then iterate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= NUM_W'(i_index) * NUM_W'(i_span);
                        r_den   <= i_den;
                        r_state <= D_INIT;
                    end
                end
                D_INIT: begin
                    r_rem   <= DEN_W'(r_num[NUM_W-1:IDX_W]);
                    r_low   <= r_num[IDX_W-1:0];
                    r_cnt   <= '0;
                    r_state <= D_ITER;
                end
                D_ITER: begin
                    r_rem <= n_step2[DEN_W-1:0];
                    r_low <= {r_low[IDX_W-3:0], n_step1[DEN_W], n_step2[DEN_W]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IDX_CNT_W'(IDX_ITER - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;
    assign o_rem  = r_rem;

endmodule

@@ rtl/grr_lane.sv @@
`timescale 1ns / 1ps
// One channel lane: weights two nodes and divides the sum by T-1, two bits a cycle.
// Depends on grr_pkg.
module grr_lane
    import grr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_weight          i_wt,
    input  logic [LVL_W-1:0] i_near,
    input  logic [LVL_W-1:0] i_far,
    output logic             o_done,
    output logic [LVL_W-1:0] o_level
);

    typedef enum logic [1:0] {L_IDLE, L_SUM, L_ITER} t_lstate;

    t_lstate              r_state;
    logic [LVL_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [PROD_W-1:0]    r_prod_near;
    logic [PROD_W-1:0]    r_prod_far;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [LVL_W-1:0]     r_low;
    logic [PROD_W-1:0]    n_sum;
    logic [DEN_W:0]       n_step1;
    logic [DEN_W:0]       n_step2;

    // The weighted sum is at most (T-1)*65535, so it fits PROD_W bits
    always_comb begin
        n_sum   = r_prod_near + r_prod_far;
        n_step1 = div_step(r_rem, r_low[LVL_W-1], r_den);
        n_step2 = div_step(n_step1[DEN_W-1:0], r_low[LVL_W-2], r_den);
    end

    // Multiply, add and load, then iterate; the quotient stays below 2**LVL_W
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_prod_near <= PROD_W'(i_wt.near) * PROD_W'(i_near);
                        r_prod_far  <= PROD_W'(i_wt.far) * PROD_W'(i_far);
                        r_den       <= i_wt.den;
                        r_state     <= L_SUM;
                    end
                end
                L_SUM: begin
                    r_rem   <= DEN_W'(n_sum[PROD_W-1:LVL_W]);
                    r_low   <= n_sum[LVL_W-1:0];
                    r_cnt   <= '0;
                    r_state <= L_ITER;
                end
                L_ITER: begin
                    r_rem <= n_step2[DEN_W-1:0];
                    r_low <= {r_low[LVL_W-3:0], n_step1[DEN_W], n_step2[DEN_W]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LVL_CNT_W'(LVL_ITER - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_level = r_low;

endmodule

@@ rtl/grr_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: gathers the lane levels and status into the output register.
// Depends on grr_pkg.
module grr_merge
    import grr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_levels           i_levels,
    input  logic [STAT_W-1:0] i_status,
    input  logic              i_out_stall,
    output logic              o_can_push,
    output logic              o_out_valid,
    output t_result           o_result
);

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    // Zero the levels on any error status
    always_comb begin
        n_result.status = i_status;
        if (i_status == STAT_OK) begin
            n_result.red   = i_levels[0];
            n_result.green = i_levels[1];
            n_result.blue  = i_levels[2];
        end else begin
            n_result.red   = '0;
            n_result.green = '0;
            n_result.blue  = '0;
        end
    end

    assign o_can_push = !r_valid || !i_out_stall;

    // Hold the result until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    // A push never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!r_valid || !i_out_stall))
        else $error("merge: push while output held");

endmodule

@@ rtl/gamma_ramp_resampler_top.sv @@
`timescale 1ns / 1ps
// Gamma ramp resampler top: node table, query sequencer, index divider,
// three channel lanes and the merge stage. Depends on grr_pkg and all grr_ modules.
//
//   port group  | direction | handshake
//   ------------+-----------+-------------------------------------------
//   input item  | in        | i_in_valid / o_in_stall
//   result      | out       | o_out_valid / i_out_stall
//   config      | in        | APB: psel, penable, pwrite, pready high
//
// A load writes the node table at its transfer; the next item is accepted in the
// following cycle. A query runs from transfer to the output register through the
// index multiply and divide, the node table read, the lane multiply, add and
// sixteen-bit divide, the hand-off to the push and the merge push; both dividers
// retire two bits a cycle. The next item transfers in the cycle after the push at
// the earliest, and an error query goes straight to the push. Input stall stays
// high during a query; a held result stalls only the push, and input stays
// stalled until that push.
// Reset clears the control state and the registers (source 0, target 256); the
// node table is undefined until written.
module gamma_ramp_resampler_top
    import grr_pkg::*;
#(
    parameter int unsigned MAX_RAMP_NODES   = DEF_RAMP_NODES,
    parameter int unsigned MAX_TARGET_NODES = DEF_TARGET_NODES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [NODE_W-1:0] i_node_addr,
    input  logic [LVL_W-1:0]  i_red_level,
    input  logic [LVL_W-1:0]  i_green_level,
    input  logic [LVL_W-1:0]  i_blue_level,
    input  logic [IDX_W-1:0]  i_output_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [LVL_W-1:0]  o_out_red,
    output logic [LVL_W-1:0]  o_out_green,
    output logic [LVL_W-1:0]  o_out_blue,
    output logic [STAT_W-1:0] o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned      AW    = $clog2(MAX_RAMP_NODES);
    localparam logic [PAR_W-1:0] MAX_S = PAR_W'(MAX_RAMP_NODES);
    localparam logic [PAR_W-1:0] MAX_T = PAR_W'(MAX_TARGET_NODES);

    typedef enum logic [2:0] {ST_IDLE, ST_IDX, ST_READ, ST_START, ST_LANE, ST_PUSH} t_state;

    // Configuration registers
    logic [SCNT_W-1:0] r_src_cnt;
    logic [TCNT_W-1:0] r_tgt_cnt;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt <= '0;
            r_tgt_cnt <= TCNT_W'(256);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_SRC: r_src_cnt <= pwdata[SCNT_W-1:0];
                REG_TGT: r_tgt_cnt <= pwdata[TCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SRC: prdata = DATA_W'(r_src_cnt);
            REG_TGT: prdata = DATA_W'(r_tgt_cnt);
            default: prdata = '0;
        endcase
    end

    // Saturate the counts to the table and ramp sizes
    logic [SCNT_W-1:0] w_src_eff;
    logic [TCNT_W-1:0] w_tgt_eff;
    logic [SCNT_W-1:0] w_span;
    logic [DEN_W-1:0]  w_den;

    assign w_src_eff = (PAR_W'(r_src_cnt) > MAX_S) ? SCNT_W'(MAX_S) : r_src_cnt;
    assign w_tgt_eff = (PAR_W'(r_tgt_cnt) > MAX_T) ? TCNT_W'(MAX_T) : r_tgt_cnt;
    assign w_span    = w_src_eff - 1'b1;
    assign w_den     = DEN_W'(w_tgt_eff - 1'b1);

    // Input transfer and query checks
    t_state            r_state;
    logic              w_in_xfer;
    logic              w_query;
    logic              w_load_wr;
    logic [STAT_W-1:0] n_status;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_query    = w_in_xfer && (i_operation == OP_QUERY);
    assign w_load_wr  = w_in_xfer && (i_operation == OP_LOAD)
                        && (PAR_W'(i_node_addr) < MAX_S);

    always_comb begin
        if ((w_src_eff < SCNT_W'(2)) || (w_tgt_eff < TCNT_W'(2))) begin
            n_status = STAT_FEW;
        end else if (TCNT_W'(i_output_index) >= w_tgt_eff) begin
            n_status = STAT_RANGE;
        end else begin
            n_status = STAT_OK;
        end
    end

    // Index divider
    logic             w_idx_start;
    logic             w_idx_done;
    logic [IDX_W-1:0] w_quot;
    logic [DEN_W-1:0] w_rem;

    assign w_idx_start = w_query && (n_status == STAT_OK);

    grr_idx_div u_idx_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_idx_start),
        .i_index (i_output_index),
        .i_span  (w_span),
        .i_den   (w_den),
        .o_done  (w_idx_done),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // Clamp q and pick the upper neighbor
    logic [IDX_W-1:0] w_q;
    logic [IDX_W-1:0] w_qn;

    assign w_q  = (w_quot > IDX_W'(w_span)) ? IDX_W'(w_span) : w_quot;
    assign w_qn = (w_q < IDX_W'(w_span)) ? (w_q + 1'b1) : IDX_W'(w_span);

    // Node table: one write port, two registered read ports
    logic [AW-1:0] r_qa;
    logic [AW-1:0] r_qb;
    t_levels       r_mem [MAX_RAMP_NODES];
    t_levels       r_rd_a;
    t_levels       r_rd_b;

    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            r_mem[AW'(i_node_addr)] <= {i_blue_level, i_green_level, i_red_level};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[r_qa];
        r_rd_b <= r_mem[r_qb];
    end

    // Channel lanes
    t_weight          r_wt;
    logic [LANES-1:0] w_lane_done;
    t_levels          w_lane_level;
    logic             w_lane_start;

    assign w_lane_start = (r_state == ST_START);

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        grr_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_lane_start),
            .i_wt    (r_wt),
            .i_near  (r_rd_a[c]),
            .i_far   (r_rd_b[c]),
            .o_done  (w_lane_done[c]),
            .o_level (w_lane_level[c])
        );
    end

    // Merge stage
    logic              w_can_push;
    logic              w_push;
    logic [STAT_W-1:0] r_status;
    t_result           w_result;

    assign w_push = (r_state == ST_PUSH) && w_can_push;

    grr_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_levels    (w_lane_level),
        .i_status    (r_status),
        .i_out_stall (i_out_stall),
        .o_can_push  (w_can_push),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_out_red   = w_result.red;
    assign o_out_green = w_result.green;
    assign o_out_blue  = w_result.blue;
    assign o_status    = w_result.status;

    // Query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_query) begin
                        r_status <= n_status;
                        r_state  <= (n_status == STAT_OK) ? ST_IDX : ST_PUSH;
                    end
                end
                ST_IDX: begin
                    if (w_idx_done) begin
                        r_qa      <= AW'(w_q);
                        r_qb      <= AW'(w_qn);
                        r_wt.den  <= w_den;
                        r_wt.near <= w_den - w_rem;
                        r_wt.far  <= w_rem;
                        r_state   <= ST_READ;
                    end
                end
                ST_READ:  r_state <= ST_START;
                ST_START: r_state <= ST_LANE;
                ST_LANE: begin
                    if (w_lane_done[0]) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (w_can_push) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The lanes start together and must finish together
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lane_done[0] == w_lane_done[1]) && (w_lane_done[1] == w_lane_done[2]))
        else $error("top: lane completion out of step");

    // The index divider only reports while a query waits for it
    a_idx_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idx_done |-> (r_state == ST_IDX))
        else $error("top: index divider done outside its wait");

    // Blend weights add up to T-1 and the neighbors are ordered
    a_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |-> (((r_wt.near + r_wt.far) == r_wt.den) && (r_qa <= r_qb)))
        else $error("top: inconsistent blend weights");

endmodule

@@ bench/gamma_ramp_resampler_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for gamma_ramp_resampler_top: loads ramp nodes, queries resampled
// points and checks every result against an integer interpolation model kept in the bench.
// Depends on grr_pkg and the rtl modules under rtl/.
module gamma_ramp_resampler_top_tb;
    import grr_pkg::*;

    localparam int unsigned          TOTAL_ITEMS    = 1650;
    localparam int unsigned          SETTLE_CYCLES  = 32;     // query latency plus margin
    localparam int unsigned          HOLD_CYCLES    = 300;
    localparam int unsigned          WATCHDOG_LIMIT = 5000;
    localparam logic [LVL_W-1:0]     FULL_SCALE     = 16'hFF00;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    // DUT ports; the bench drives its inputs to known values from time zero
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic              i_operation    = OP_LOAD;
    logic [NODE_W-1:0] i_node_addr    = '0;
    logic [LVL_W-1:0]  i_red_level    = '0;
    logic [LVL_W-1:0]  i_green_level  = '0;
    logic [LVL_W-1:0]  i_blue_level   = '0;
    logic [IDX_W-1:0]  i_output_index = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [LVL_W-1:0]  o_out_red;
    logic [LVL_W-1:0]  o_out_green;
    logic [LVL_W-1:0]  o_out_blue;
    logic [STAT_W-1:0] o_status;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [DATA_W-1:0] pwdata         = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Bench copy of the block state
    t_levels           node_levels [DEF_RAMP_NODES];
    bit                node_loaded [DEF_RAMP_NODES];
    logic [SCNT_W-1:0] src_cnt = '0;
    logic [TCNT_W-1:0] tgt_cnt = TCNT_W'(256);
    t_result           ramp_results_due [$];

    // Pacing and bookkeeping
    bit                sender_gaps  = 1'b1;
    int unsigned       burst_left   = 0;
    t_stall_mode       stall_mode   = STALL_LIGHT;
    bit                hold_req     = 1'b0;
    int unsigned       items_sent   = 0;
    int unsigned       loads_sent   = 0;
    int unsigned       queries_sent = 0;
    int unsigned       settings_tried = 0;
    int unsigned       results_checked = 0;
    int unsigned       status_seen [3] = '{0, 0, 0};
    int unsigned       mismatches   = 0;

    gamma_ramp_resampler_top u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Effective counts after saturation to the table and target limits
    function automatic int unsigned eff_src();
        return (src_cnt > DEF_RAMP_NODES) ? DEF_RAMP_NODES : int'(src_cnt);
    endfunction

    function automatic int unsigned eff_tgt();
        return (tgt_cnt > DEF_TARGET_NODES) ? DEF_TARGET_NODES : int'(tgt_cnt);
    endfunction

    // Map output position to the two bracketing source nodes and the remainder
    function automatic void split_index(input int unsigned idx, input int unsigned s,
                                        input int unsigned t, output int unsigned q,
                                        output int unsigned qn, output int unsigned r);
        int unsigned num;
        num = idx * (s - 1);
        q   = num / (t - 1);
        r   = num % (t - 1);
        if (q > s - 1) q = s - 1;
        qn  = (q + 1 < s) ? q + 1 : s - 1;
    endfunction

    function automatic bit query_reads_loaded(input int unsigned idx);
        int unsigned s, t, q, qn, r;
        s = eff_src();
        t = eff_tgt();
        if (s < 2 || t < 2 || idx >= t) return 1'b1;
        split_index(idx, s, t, q, qn, r);
        return node_loaded[q] && node_loaded[qn];
    endfunction

    // Expected result of one query under the current counts and node table
    function automatic t_result resample_point(input logic [IDX_W-1:0] idx);
        int unsigned       s, t, q, qn, r, c;
        longint unsigned   w_near, w_far, den, acc;
        t_levels           blended;
        t_result           res;
        s   = eff_src();
        t   = eff_tgt();
        res = '0;
        if (s < 2 || t < 2) begin
            res.status = STAT_FEW;
        end else if (idx >= t) begin
            res.status = STAT_RANGE;
        end else begin
            split_index(idx, s, t, q, qn, r);
            den    = t - 1;
            w_near = den - r;
            w_far  = r;
            for (c = 0; c < LANES; c++) begin
                acc        = (w_near * node_levels[q][c] + w_far * node_levels[qn][c]) / den;
                blended[c] = acc[LVL_W-1:0];
            end
            res.red    = blended[0];
            res.green  = blended[1];
            res.blue   = blended[2];
            res.status = STAT_OK;
        end
        return res;
    endfunction

    // Mostly in-range positions, some endpoints and some anywhere; avoids unloaded nodes, else position 0
    function automatic logic [IDX_W-1:0] pick_query_index();
        int unsigned t, sel, tries, idx;
        t = eff_tgt();
        for (tries = 0; tries < 16; tries++) begin
            sel = $urandom_range(0, 9);
            if (t == 0 || sel >= 8) begin
                idx = $urandom_range(0, (1 << IDX_W) - 1);
            end else if (sel < 7) begin
                idx = $urandom_range(0, t - 1);
            end else begin
                case ($urandom_range(0, 2))
                    0:       idx = 0;
                    1:       idx = t - 1;
                    default: idx = (t < (1 << IDX_W)) ? t : t - 1;
                endcase
            end
            if (query_reads_loaded(idx)) return IDX_W'(idx);
        end
        return '0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t ns: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one item, hold it until the transfer, update the model, then pace
    task automatic send_item(input logic op, input logic [NODE_W-1:0] node,
                             input t_levels lv, input logic [IDX_W-1:0] idx);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_node_addr    <= node;
        i_red_level    <= lv[0];
        i_green_level  <= lv[1];
        i_blue_level   <= lv[2];
        i_output_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (op == OP_LOAD) begin
            node_levels[node] = lv;
            node_loaded[node] = 1'b1;
            loads_sent++;
        end else begin
            ramp_results_due.insert(ramp_results_due.size(), resample_point(idx));
            queries_sent++;
        end
        if (sender_gaps) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic load_node(input int unsigned node, input logic [LVL_W-1:0] r,
                             input logic [LVL_W-1:0] g, input logic [LVL_W-1:0] b);
        send_item(OP_LOAD, NODE_W'(node), {b, g, r}, IDX_W'($urandom));
    endtask

    task automatic query_point(input int unsigned idx);
        send_item(OP_QUERY, NODE_W'($urandom),
                  {16'($urandom), 16'($urandom), 16'($urandom)}, IDX_W'(idx));
    endtask

    // Drop valid, drain all due results, then let the last item retire
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (ramp_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access until pready
    task automatic write_reg(input logic sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_SRC) src_cnt = value[SCNT_W-1:0];
        else                tgt_cnt = value[TCNT_W-1:0];
    endtask

    task automatic set_counts(input int unsigned s_raw, input int unsigned t_raw);
        wait_idle();
        write_reg(REG_SRC, s_raw);
        write_reg(REG_TGT, t_raw);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_tried++;
    endtask

    // Counts straight out of reset: no nodes in use
    task automatic test_reset_defaults();
        query_point(0);
        query_point((1 << IDX_W) - 1);
    endtask

    // Two-node ramp, exact endpoints, positions past target and too few nodes
    task automatic test_two_node_ramp();
        set_counts(2, 2);
        load_node(0, 16'd0, 16'd0, 16'd0);
        load_node(1, 16'hFFFF, FULL_SCALE, 16'h8001);
        query_point(0);
        query_point(1);
        query_point(2);
        query_point((1 << IDX_W) - 1);
        set_counts(2, 1);
        query_point(0);
        set_counts(1, 2);
        query_point(0);
        set_counts(2, 0);
        query_point(1);
    endtask

    // Three nodes onto five positions: half-way blends between nodes
    task automatic test_interpolation();
        int unsigned k;
        set_counts(3, 5);
        load_node(2, FULL_SCALE, 16'h1234, 16'hFFFF);
        for (k = 0; k < 5; k++) query_point(k);
    endtask

    // Counts above the table and target limits saturate
    task automatic test_saturated_counts();
        set_counts((1 << SCNT_W) - 1, (1 << TCNT_W) - 1);
        load_node(DEF_RAMP_NODES - 2, 16'h0101, 16'hFEFE, 16'h7FFF);
        load_node(DEF_RAMP_NODES - 1, 16'hAAAA, 16'h5555, 16'hFFFF);
        query_point(0);
        query_point(1);
        query_point(DEF_TARGET_NODES - 2);
        query_point(DEF_TARGET_NODES - 1);
        set_counts(DEF_RAMP_NODES, DEF_TARGET_NODES);
        query_point(0);
    endtask

    // Receiver holds off for a long stretch while queries keep coming
    task automatic test_output_backpressure();
        int unsigned k;
        set_counts(3, 64);
        sender_gaps = 1'b0;
        stall_mode  = STALL_NONE;
        hold_req    = 1'b1;
        for (k = 0; k < 12; k++) query_point(pick_query_index());
    endtask

    // Random count settings, each followed by a ramp load and a run of queries
    task automatic test_random_ramps();
        int unsigned s_raw, t_raw, s_eff, n_nodes, n_query, k, c, sel, node, base;
        t_levels     lv;
        while (items_sent < TOTAL_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)      s_raw = $urandom_range(2, 48);
            else if (sel < 16) s_raw = $urandom_range(0, 1);
            else if (sel < 18) s_raw = $urandom_range(49, DEF_RAMP_NODES);
            else               s_raw = $urandom_range(DEF_RAMP_NODES, (1 << SCNT_W) - 1);
            sel = $urandom_range(0, 19);
            if (sel < 12)      t_raw = $urandom_range(2, 300);
            else if (sel < 14) t_raw = $urandom_range(0, 1);
            else if (sel < 17) t_raw = $urandom_range(301, DEF_TARGET_NODES);
            else               t_raw = $urandom_range(DEF_TARGET_NODES, (1 << TCNT_W) - 1);
            // junk above the register width now and then
            if ($urandom_range(0, 3) == 0) s_raw = s_raw | ($urandom << SCNT_W);
            if ($urandom_range(0, 3) == 0) t_raw = t_raw | ($urandom << TCNT_W);
            set_counts(s_raw, t_raw);
            s_eff       = eff_src();
            sender_gaps = ($urandom_range(0, 3) != 0);
            stall_mode  = t_stall_mode'($urandom_range(0, 2));

            // small ramps are loaded whole, large ones sparsely with both ends
            n_nodes = (s_eff < 2) ? 2 : s_eff;
            if (n_nodes <= 64) begin
                for (k = 0; k < n_nodes; k++) begin
                    base = k * FULL_SCALE / (n_nodes - 1);
                    for (c = 0; c < LANES; c++) begin
                        lv[c] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                            : 16'(base + $urandom_range(0, 255));
                    end
                    load_node(k, lv[0], lv[1], lv[2]);
                end
            end else begin
                for (k = 0; k < 24; k++) begin
                    case (k)
                        0:       node = 0;
                        1:       node = 1;
                        2:       node = n_nodes - 2;
                        3:       node = n_nodes - 1;
                        default: node = $urandom_range(0, n_nodes - 1);
                    endcase
                    load_node(node, 16'($urandom), 16'($urandom), 16'($urandom));
                end
            end

            // queries with the odd stray load mixed in
            n_query = $urandom_range(6, 24);
            for (k = 0; k < n_query; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    load_node($urandom_range(0, DEF_RAMP_NODES - 1),
                              16'($urandom), 16'($urandom), 16'($urandom));
                end else begin
                    query_point(pick_query_index());
                end
            end
        end
    endtask

    // Result stall: random go/stall runs, plus a long hold on request
    initial begin : out_stall_gen
        int unsigned run_left, hold_left;
        run_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else if (stall_mode == STALL_NONE || i_out_stall) begin
                i_out_stall <= 1'b0;
                run_left = (stall_mode == STALL_HEAVY) ? $urandom_range(0, 4)
                                                       : $urandom_range(1, 16);
            end else begin
                i_out_stall <= 1'b1;
                run_left = (stall_mode == STALL_HEAVY) ? $urandom_range(0, 10)
                                                       : $urandom_range(0, 3);
            end
        end
    end

    // Compare each result transfer with the oldest due result
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ramp_results_due.size() == 0) begin
                report_mismatch("result with none due, status", o_status, 0);
            end else begin
                want = ramp_results_due.pop_front();
                if (o_out_red !== want.red)      report_mismatch("red", o_out_red, want.red);
                if (o_out_green !== want.green)  report_mismatch("green", o_out_green, want.green);
                if (o_out_blue !== want.blue)    report_mismatch("blue", o_out_blue, want.blue);
                if (o_status !== want.status)    report_mismatch("status", o_status, want.status);
                if (want.status <= STAT_RANGE) status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pwrite && pready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles without a transfer", quiet);
        $display("gamma_ramp_resampler_top verification failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_two_node_ramp();
        test_interpolation();
        test_saturated_counts();
        test_output_backpressure();
        test_random_ramps();
        wait_idle();
        $display("run covered %0d node loads and %0d queries over %0d count settings",
                 loads_sent, queries_sent, settings_tried);
        $display("%0d results checked: %0d interpolated, %0d too few nodes, %0d past target",
                 results_checked, status_seen[STAT_OK], status_seen[STAT_FEW],
                 status_seen[STAT_RANGE]);
        if (mismatches == 0) begin
            $display("gamma_ramp_resampler_top verification clean");
        end else begin
            $display("gamma_ramp_resampler_top verification failed");
        end
        $finish;
    end

endmodule
